// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Checks compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: %m");

// Condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition: %m");

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ===== hdl/pts_pkg.sv =====
// ---------------------------------------------------------------------------
// pts_pkg: shared constants and types for the table index sampler
// Table geometry, field widths and the packed layout of one table row.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pts_pkg;

  localparam int NUM_ROWS  = 32;
  localparam int ROW_W     = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int SEL_W     = 5;
  localparam int WEIGHT_W  = 32;
  localparam int COUNT_W   = 16;
  localparam int OFFSET_W  = 20;
  localparam int LOC_W     = 21;
  localparam int PROD_W    = WEIGHT_W + COUNT_W;
  localparam int DIVCNT_W  = $clog2(PROD_W);

  typedef logic [ROW_W-1:0]    row_t;
  typedef logic [SEL_W-1:0]    sel_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [OFFSET_W-1:0] offset_t;
  typedef logic [LOC_W-1:0]    loc_t;
  typedef logic [PROD_W-1:0]   prod_t;
  typedef logic [DIVCNT_W-1:0] divcnt_t;

  typedef struct packed {
    weight_t weight;
    count_t  count;
    offset_t offset;
  } entry_t;

  localparam int   ENTRY_W  = $bits(entry_t);
  localparam row_t LAST_ROW = row_t'(NUM_ROWS - 1);

endpackage

// ===== hdl/pts_ram.sv =====
// ---------------------------------------------------------------------------
// pts_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(DEPTH)-1:0]        waddr,
  input  logic [WIDTH-1:0]                wdata,
  input  logic [$clog2(DEPTH)-1:0]        raddr,
  output logic [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/pdf_table_index_sampler.sv =====
// ---------------------------------------------------------------------------
// pdf_table_index_sampler: discrete inverse-transform sampler over a row table
// Walks weight rows from first_row, then divides remaining*count by weight
// with a bit-serial restoring divider to pick an entity within the row.
// ---------------------------------------------------------------------------
//
//  channel | signals                                              | dir
//  --------+------------------------------------------------------+-----
//  in      | in_valid/in_ready, action, row_index, weight,        | in
//          | entity_count, entity_base, uniform_value             |
//  out     | out_valid/out_ready, location, chosen_row, empty_type | out
//  cfg     | cfg_valid/cfg_ready, cfg_data (first_row)            | in
//
// Load: writes the row at row_index if in range; in_ready stays high. Sample:
// walks rows (1 to NUM_ROWS, one table RAM read each; the last also forms the
// product, or all ones if its weight is zero), then a PROD_W (48) bit divide
// unless the row has zero count or weight, then the output step frees in_ready.
// The divider is one shared 33-bit compare/subtract used once per quotient bit.
// Reset is synchronous; the table RAM is not cleared. A full output register
// stalls the output step; a result waits there while the next item is taken.
`timescale 1ns / 1ps

module pdf_table_index_sampler (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     action,
  input  logic [4:0]               row_index,
  input  logic [31:0]              weight,
  input  logic [15:0]              entity_count,
  input  logic [19:0]              entity_base,
  input  logic [31:0]              uniform_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [20:0]              location,
  output logic [4:0]               chosen_row,
  output logic                     empty_type,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [4:0]               cfg_data
);

  `include "assert_macros.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  logic [2:0]           state;
  logic [2:0]           state_next;
  pts_pkg::sel_t        first_row;
  pts_pkg::row_t        row;
  pts_pkg::row_t        row_next;
  pts_pkg::row_t        start_row;
  pts_pkg::weight_t     rem;
  pts_pkg::weight_t     rem_next;
  pts_pkg::entry_t      rd_entry;
  pts_pkg::entry_t      wr_entry;
  logic                 tbl_we;
  logic                 advance;
  logic                 in_fire;
  logic                 out_free;
  pts_pkg::weight_t     div_w;
  pts_pkg::count_t      cnt_r;
  pts_pkg::offset_t     off_r;
  logic                 empty_r;
  pts_pkg::prod_t       quo;
  pts_pkg::weight_t     part;
  pts_pkg::divcnt_t     div_cnt;
  logic [pts_pkg::WEIGHT_W:0] part_sh;
  logic                 part_ge;
  pts_pkg::count_t      num;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Saturate the start row to the last table row
  assign start_row = (int'(first_row) > pts_pkg::NUM_ROWS - 1) ? pts_pkg::LAST_ROW
                                                                : pts_pkg::row_t'(first_row);

  assign tbl_we = in_fire && !action && (int'(row_index) < pts_pkg::NUM_ROWS);
  assign wr_entry = '{weight: weight, count: entity_count, offset: entity_base};

  pts_ram #(
    .WIDTH (pts_pkg::ENTRY_W),
    .DEPTH (pts_pkg::NUM_ROWS)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (pts_pkg::row_t'(row_index)),
    .wdata (wr_entry),
    .raddr (row_next),
    .rdata (rd_entry)
  );

  assign advance = (row != pts_pkg::LAST_ROW) && (rd_entry.weight < rem);

  // Divider step: shift in the next dividend bit, subtract when it fits
  assign part_sh = {part, quo[pts_pkg::PROD_W-1]};
  assign part_ge = (part_sh >= {1'b0, div_w});

  // Clamp quotient to count-1; an empty row contributes nothing
  always_comb begin
    if (empty_r) begin
      num = '0;
    end else if (quo >= pts_pkg::prod_t'(cnt_r)) begin
      num = cnt_r - 1'b1;
    end else begin
      num = quo[pts_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    row_next   = row;
    rem_next   = rem;
    case (state)
      S_IDLE: begin
        if (in_fire && action) begin
          state_next = S_WALK;
          row_next   = start_row;
          rem_next   = uniform_value;
        end
      end
      S_WALK: begin
        if (advance) begin
          row_next = row + 1'b1;
          rem_next = rem - rd_entry.weight;
        end else if (rd_entry.count == '0 || rd_entry.weight == '0) begin
          state_next = S_DONE;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_cnt == pts_pkg::divcnt_t'(pts_pkg::PROD_W - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      first_row <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        first_row <= cfg_data;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    row <= row_next;
    rem <= rem_next;
    if (state == S_WALK && !advance) begin
      div_w   <= rd_entry.weight;
      cnt_r   <= rd_entry.count;
      off_r   <= rd_entry.offset;
      empty_r <= (rd_entry.count == '0);
      part    <= '0;
      div_cnt <= '0;
      // zero weight: force the clamp to count-1
      if (rd_entry.weight == '0) begin
        quo <= '1;
      end else begin
        quo <= pts_pkg::prod_t'(rem) * pts_pkg::prod_t'(rd_entry.count);
      end
    end else if (state == S_DIV) begin
      part    <= part_ge ? pts_pkg::weight_t'(part_sh - {1'b0, div_w})
                         : pts_pkg::weight_t'(part_sh);
      quo     <= {quo[pts_pkg::PROD_W-2:0], part_ge};
      div_cnt <= div_cnt + 1'b1;
    end
    if (state == S_DONE && out_free) begin
      location   <= pts_pkg::loc_t'(off_r) + pts_pkg::loc_t'(num);
      chosen_row <= pts_pkg::sel_t'(row);
      empty_type <= empty_r;
    end
  end

  `ASSERT_CLK(a_sample_starts_walk, clk, rst, in_valid && in_ready && action |=> state == S_WALK)
  `ASSERT_NEVER(a_row_in_table, clk, rst, state == S_WALK && int'(row) > pts_pkg::NUM_ROWS - 1)
  `ASSERT_NEVER(a_part_below_divisor, clk, rst, state == S_DIV && part >= div_w)
  `ASSERT_CLK(a_done_holds_on_stall, clk, rst, state == S_DONE && out_valid && !out_ready |=> state == S_DONE)

endmodule
